// File: rtl/core/pltm_pkg.sv
// shared types and constants for the packet latency traffic monitor
`default_nettype none
package pltm_pkg;
    localparam int SEQ_SLOTS    = 128;
    localparam int SAMPLE_SLOTS = 128;
    localparam int SEQ_W        = $clog2(SEQ_SLOTS);
    localparam int SMP_W        = $clog2(SAMPLE_SLOTS);
    localparam int QCNT_W       = SMP_W + 1;
    localparam int FIFO_DEPTH   = 2;

    typedef enum logic [1:0] {
        OP_SEND   = 2'd0,
        OP_RECV   = 2'd1,
        OP_REPORT = 2'd2,
        OP_READ   = 2'd3
    } t_op;

    typedef enum logic [1:0] {
        REG_RATE_WINDOW = 2'd0,
        REG_STALE_LIMIT = 2'd1,
        REG_INTERVAL    = 2'd2,
        REG_MIN_SAMPLES = 2'd3
    } t_reg;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_FETCH,
        ST_EXEC,
        ST_DIV,
        ST_OUT
    } t_state;

    typedef struct packed {
        t_op         op;
        logic [31:0] now_ms;
        logic [15:0] byte_count;
        logic [6:0]  seq;
        logic [15:0] server_hold_ms;
        logic [6:0]  sample_index;
    } t_item;

    typedef struct packed {
        logic [6:0]  seq_assigned;
        logic        match_ok;
        logic [31:0] ping_ms;
        logic [15:0] server_ms;
        logic [31:0] interval_ms;
        logic [39:0] rate_value;
        logic        rate_stale;
        logic [31:0] packets_last_window;
        logic [31:0] sent_total;
        logic [31:0] recv_total;
        logic [31:0] avg_interval_ms;
        logic        avg_ready;
    } t_result;

    typedef struct packed {
        logic [15:0] rate_window_ms;
        logic [15:0] stale_limit_ms;
        logic [15:0] interval_limit_ms;
        logic [6:0]  min_samples;
    } t_cfg;
endpackage
`default_nettype wire

// File: rtl/core/pltm_ram.sv
// generic single write port ram with registered read
`default_nettype none
module pltm_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 128
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_we,
    input  wire logic [$clog2(DEPTH)-1:0] i_waddr,
    input  wire logic [WIDTH-1:0]         i_wdata,
    input  wire logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic      [WIDTH-1:0]         o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata <= r_mem[i_raddr];
    end
endmodule
`default_nettype wire

// File: rtl/core/pltm_front.sv
// input side: accepts items into a short queue
`default_nettype none
module pltm_front (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire logic          i_valid,
    output logic               o_ready,
    input  wire pltm_pkg::t_item i_item,
    output logic               o_q_valid,
    output pltm_pkg::t_item    o_q_item,
    input  wire logic          i_q_pop
);
    import pltm_pkg::*;

    localparam int PW = $clog2(FIFO_DEPTH);

    t_item           r_buf [FIFO_DEPTH];
    logic [PW-1:0]   r_wp, r_rp;
    logic [PW:0]     r_cnt;
    logic            push;

    assign o_ready   = (r_cnt != (PW+1)'(FIFO_DEPTH));
    assign push      = i_valid && o_ready;
    assign o_q_valid = (r_cnt != '0);
    assign o_q_item  = r_buf[r_rp];

    always_ff @(posedge i_clk) begin
        if (push) begin
            r_buf[r_wp] <= i_item;
        end
        if (!i_rst_n) begin
            r_wp  <= '0;
            r_rp  <= '0;
            r_cnt <= '0;
        end else begin
            if (push) begin
                r_wp <= r_wp + 1'b1;
            end
            if (i_q_pop) begin
                r_rp <= r_rp + 1'b1;
            end
            r_cnt <= r_cnt + (PW+1)'(push) - (PW+1)'(i_q_pop);
        end
    end
endmodule
`default_nettype wire

// File: rtl/core/pltm_back.sv
// execution side: stamps, sample ring, counters and mean divider
`default_nettype none
module pltm_back (
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    input  wire pltm_pkg::t_cfg   i_cfg,
    input  wire logic             i_q_valid,
    input  wire pltm_pkg::t_item  i_q_item,
    output logic                  o_q_pop,
    output logic                  o_valid,
    input  wire logic             i_ready,
    output pltm_pkg::t_result     o_res
);
    import pltm_pkg::*;

    t_state r_state, n_state;
    t_item  r_it;
    t_result r_res;

    logic [SEQ_SLOTS-1:0] r_live;
    logic [SEQ_W-1:0]     r_send_pos;
    logic [SMP_W-1:0]     r_ring_pos;
    logic [31:0]          r_last_rx;
    logic                 r_seen_rx;
    logic [39:0]          r_isum;
    logic [QCNT_W-1:0]    r_iqual;
    logic [31:0]          r_win_start;
    logic [39:0]          r_win_bytes;
    logic [31:0]          r_win_pkts, r_closed_pkts, r_mean, r_sends, r_recvs;
    logic [39:0]          r_closed_rate;
    logic [SAMPLE_SLOTS-1:0] r_svalid;

    // divider
    logic [39:0] r_rem, r_quo;
    logic [5:0]  r_dcnt;

    // ram signals
    logic              stamp_we, smp_we;
    logic [SEQ_W-1:0]  stamp_waddr, stamp_raddr;
    logic [31:0]       stamp_rd;
    logic [SMP_W-1:0]  smp_raddr;
    logic [79:0]       smp_wdata, smp_rd;

    // derived values
    logic [SEQ_W:0]    send_inc;
    logic [SEQ_W-1:0]  send_nxt;
    logic              send_wrap;
    logic              seq_in_range, rx_match;
    logic [31:0]       old_iv, old_ping, iv_new, ping;
    logic [15:0]       old_srv;
    logic              old_q, new_q, old_ok;
    logic [31:0]       dt;
    logic [40:0]       bsum;
    logic [39:0]       bsat;
    logic [43:0]       b9;
    logic              win_close;
    logic              mean_upd;
    logic [40:0]       dsub;

    pltm_ram #(.WIDTH(32), .DEPTH(SEQ_SLOTS)) u_stamp (
        .i_clk, .i_we(stamp_we), .i_waddr(stamp_waddr), .i_wdata(r_it.now_ms),
        .i_raddr(stamp_raddr), .o_rdata(stamp_rd)
    );
    pltm_ram #(.WIDTH(80), .DEPTH(SAMPLE_SLOTS)) u_smp (
        .i_clk, .i_we(smp_we), .i_waddr(r_ring_pos), .i_wdata(smp_wdata),
        .i_raddr(smp_raddr), .o_rdata(smp_rd)
    );

    assign send_inc  = {1'b0, r_send_pos} + 1'b1;
    assign send_wrap = (send_inc >= (SEQ_W+1)'(SEQ_SLOTS));
    assign send_nxt  = send_wrap ? '0 : send_inc[SEQ_W-1:0];

    assign seq_in_range = ({25'd0, r_it.seq} < 32'(SEQ_SLOTS));
    assign rx_match     = seq_in_range && r_live[r_it.seq[SEQ_W-1:0]];

    // ring fetch in the fetch cycle: op 3 reads sample_index, op 1 the entry to overwrite
    assign smp_raddr   = (r_it.op == OP_READ) ?
                         r_it.sample_index[SMP_W-1:0] : r_ring_pos;
    assign stamp_raddr = r_it.seq[SEQ_W-1:0];

    assign old_ok   = r_svalid[r_ring_pos];
    assign old_iv   = old_ok ? smp_rd[31:0] : 32'd0;
    assign old_srv  = smp_rd[47:32];
    assign old_ping = smp_rd[79:48];
    assign iv_new   = r_seen_rx ? (r_it.now_ms - r_last_rx) : old_iv;
    assign ping     = r_it.now_ms - stamp_rd - {16'd0, r_it.server_hold_ms};
    assign old_q    = (old_iv != 0) && (old_iv < {16'd0, i_cfg.interval_limit_ms});
    assign new_q    = (iv_new != 0) && (iv_new < {16'd0, i_cfg.interval_limit_ms});
    assign smp_wdata = {ping, r_it.server_hold_ms, iv_new};

    assign dt        = r_it.now_ms - r_win_start;
    assign bsum      = {1'b0, r_win_bytes} + {25'd0, r_it.byte_count};
    assign bsat      = bsum[40] ? {40{1'b1}} : bsum[39:0];
    assign b9        = {4'd0, r_win_bytes} + {r_win_bytes, 3'd0};
    assign win_close = (dt > {16'd0, i_cfg.rate_window_ms});
    assign mean_upd  = (r_ring_pos >= i_cfg.min_samples);

    assign dsub = {r_rem[38:0], r_isum[39 - r_dcnt]} - {33'd0, r_iqual};

    assign stamp_we    = (r_state == ST_EXEC) && (r_it.op == OP_SEND);
    assign stamp_waddr = send_nxt;
    assign smp_we      = (r_state == ST_EXEC) && (r_it.op == OP_RECV) && rx_match;

    // next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            ST_IDLE:  if (i_q_valid) n_state = ST_FETCH;
            ST_FETCH: n_state = ST_EXEC;
            ST_EXEC:  n_state = ((r_it.op == OP_REPORT) && mean_upd && (r_iqual != '0)) ?
                                ST_DIV : ST_OUT;
            ST_DIV:   if (r_dcnt == 6'd39) n_state = ST_OUT;
            ST_OUT:   if (i_ready) n_state = ST_IDLE;
            default:  n_state = ST_IDLE;
        endcase
    end

    // outputs
    always_comb begin
        o_q_pop = (r_state == ST_IDLE) && i_q_valid;
        o_valid = (r_state == ST_OUT);
        o_res   = r_res;
    end

    always_ff @(posedge i_clk) begin
        if (o_q_pop) begin
            r_it <= i_q_item;
        end
        if (r_state == ST_DIV) begin
            r_rem  <= dsub[40] ? {r_rem[38:0], r_isum[39 - r_dcnt]} : dsub[39:0];
            r_quo  <= {r_quo[38:0], ~dsub[40]};
            r_dcnt <= r_dcnt + 1'b1;
        end
        if (r_state == ST_EXEC) begin
            r_res <= '0;
            r_rem  <= '0;
            r_quo  <= '0;
            r_dcnt <= '0;
            unique case (r_it.op)
                OP_SEND: r_res.seq_assigned <= 7'(send_nxt);
                OP_RECV: if (rx_match) begin
                    r_res.match_ok    <= 1'b1;
                    r_res.ping_ms     <= ping;
                    r_res.server_ms   <= r_it.server_hold_ms;
                    r_res.interval_ms <= r_seen_rx ? iv_new : 32'd0;
                end
                OP_REPORT: begin
                    r_res.rate_value <= win_close ? b9[43:4] >> 6 : r_closed_rate;
                    r_res.rate_stale <= (dt > {16'd0, i_cfg.stale_limit_ms});
                    r_res.packets_last_window <= win_close ? r_win_pkts : r_closed_pkts;
                    r_res.sent_total <= r_sends;
                    r_res.recv_total <= r_recvs;
                    r_res.avg_interval_ms <= (mean_upd && r_iqual == '0) ? 32'd0 : r_mean;
                    r_res.avg_ready <= mean_upd;
                end
                OP_READ: if ({25'd0, r_it.sample_index} < 32'(SAMPLE_SLOTS)) begin
                    r_res.match_ok <= 1'b1;
                    if (r_svalid[r_it.sample_index[SMP_W-1:0]]) begin
                        r_res.ping_ms     <= old_ping;
                        r_res.server_ms   <= old_srv;
                        r_res.interval_ms <= smp_rd[31:0];
                    end
                end
                default: ;
            endcase
        end
        if (r_state == ST_DIV && r_dcnt == 6'd39) begin
            r_res.avg_interval_ms <= {r_quo[30:0], ~dsub[40]};
        end
        if (!i_rst_n) begin
            r_state       <= ST_IDLE;
            r_live        <= '0;
            r_svalid      <= '0;
            r_send_pos    <= '0;
            r_ring_pos    <= '0;
            r_last_rx     <= '0;
            r_seen_rx     <= 1'b0;
            r_isum        <= '0;
            r_iqual       <= '0;
            r_win_start   <= '0;
            r_win_bytes   <= '0;
            r_win_pkts    <= '0;
            r_closed_pkts <= '0;
            r_closed_rate <= '0;
            r_mean        <= '0;
            r_sends       <= '0;
            r_recvs       <= '0;
        end else begin
            r_state <= n_state;
            if (r_state == ST_DIV && r_dcnt == 6'd39) begin
                r_mean <= {r_quo[30:0], ~dsub[40]};
            end
            if (r_state == ST_EXEC) begin
                unique case (r_it.op)
                    OP_SEND: begin
                        r_win_bytes <= bsat;
                        r_win_pkts  <= r_win_pkts + 1'b1;
                        r_sends     <= r_sends + 1'b1;
                        r_send_pos  <= send_nxt;
                        if (send_wrap) begin
                            r_live <= '0;
                        end
                        r_live[send_nxt] <= 1'b1;
                    end
                    OP_RECV: begin
                        r_win_bytes <= bsat;
                        r_win_pkts  <= r_win_pkts + 1'b1;
                        r_recvs     <= r_recvs + 1'b1;
                        if (rx_match) begin
                            r_svalid[r_ring_pos] <= 1'b1;
                            if (r_seen_rx) begin
                                r_isum  <= r_isum - (old_q ? {8'd0, old_iv} : 40'd0)
                                                  + (new_q ? {8'd0, iv_new} : 40'd0);
                                r_iqual <= r_iqual - QCNT_W'(old_q) + QCNT_W'(new_q);
                            end
                            r_last_rx  <= r_it.now_ms;
                            r_seen_rx  <= 1'b1;
                            r_ring_pos <= ({1'b0, r_ring_pos} + 1'b1 >=
                                           (SMP_W+1)'(SAMPLE_SLOTS)) ? '0 : r_ring_pos + 1'b1;
                            r_live[r_it.seq[SEQ_W-1:0]] <= 1'b0;
                        end
                    end
                    OP_REPORT: begin
                        if (win_close) begin
                            r_closed_rate <= b9[43:4] >> 6;
                            r_win_start   <= r_it.now_ms;
                            r_closed_pkts <= r_win_pkts;
                            r_win_pkts    <= '0;
                            r_win_bytes   <= '0;
                        end
                        if (mean_upd && r_iqual == '0) begin
                            r_mean <= '0;
                        end
                    end
                    default: ;
                endcase
            end
        end
    end
endmodule
`default_nettype wire

// File: rtl/core/packet_latency_traffic_monitor_core.sv
// top level of the packet latency traffic monitor
// an accepted item passes through the input queue and the back end states idle, fetch,
// exec and out; a report with recompute of the mean also runs the bit-serial divider
// the back end works on one item at a time
// a two entry input queue accepts items while the back end is busy
// synchronous active low reset clears counters, stamp and sample valid bits
`default_nettype none
module packet_latency_traffic_monitor_core (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_valid,
    output logic             o_ready,
    input  wire logic [1:0]  i_op,
    input  wire logic [31:0] i_now_ms,
    input  wire logic [15:0] i_byte_count,
    input  wire logic [6:0]  i_seq,
    input  wire logic [15:0] i_server_hold_ms,
    input  wire logic [6:0]  i_sample_index,
    output logic             o_valid,
    input  wire logic        i_ready,
    output logic [6:0]       o_seq_assigned,
    output logic             o_match_ok,
    output logic signed [31:0] o_ping_ms,
    output logic [15:0]      o_server_ms,
    output logic [31:0]      o_interval_ms,
    output logic [39:0]      o_rate_value,
    output logic             o_rate_stale,
    output logic [31:0]      o_packets_last_window,
    output logic [31:0]      o_sent_total,
    output logic [31:0]      o_recv_total,
    output logic [31:0]      o_avg_interval_ms,
    output logic             o_avg_ready,
    input  wire logic        psel,
    input  wire logic        penable,
    input  wire logic        pwrite,
    input  wire logic [3:0]  paddr,
    input  wire logic [31:0] pwdata,
    output logic [31:0]      prdata,
    output logic             pready
);
    import pltm_pkg::*;

    t_cfg    r_cfg;
    t_item   in_item, q_item;
    t_result res;
    logic    q_valid, q_pop;
    t_reg    reg_sel;

    assign reg_sel = t_reg'(paddr[3:2]);
    assign pready  = 1'b1;

    always_comb begin
        unique case (reg_sel)
            REG_RATE_WINDOW: prdata = {16'd0, r_cfg.rate_window_ms};
            REG_STALE_LIMIT: prdata = {16'd0, r_cfg.stale_limit_ms};
            REG_INTERVAL:    prdata = {16'd0, r_cfg.interval_limit_ms};
            REG_MIN_SAMPLES: prdata = {25'd0, r_cfg.min_samples};
            default:         prdata = '0;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.rate_window_ms    <= 16'd1000;
            r_cfg.stale_limit_ms    <= 16'd1100;
            r_cfg.interval_limit_ms <= 16'd2000;
            r_cfg.min_samples       <= 7'd10;
        end else if (psel && penable && pwrite) begin
            unique case (reg_sel)
                REG_RATE_WINDOW: r_cfg.rate_window_ms    <= pwdata[15:0];
                REG_STALE_LIMIT: r_cfg.stale_limit_ms    <= pwdata[15:0];
                REG_INTERVAL:    r_cfg.interval_limit_ms <= pwdata[15:0];
                REG_MIN_SAMPLES: r_cfg.min_samples       <= pwdata[6:0];
                default: ;
            endcase
        end
    end

    assign in_item = '{op: t_op'(i_op), now_ms: i_now_ms, byte_count: i_byte_count,
                       seq: i_seq, server_hold_ms: i_server_hold_ms,
                       sample_index: i_sample_index};

    pltm_front u_front (
        .i_clk, .i_rst_n, .i_valid, .o_ready, .i_item(in_item),
        .o_q_valid(q_valid), .o_q_item(q_item), .i_q_pop(q_pop)
    );

    pltm_back u_back (
        .i_clk, .i_rst_n, .i_cfg(r_cfg), .i_q_valid(q_valid), .i_q_item(q_item),
        .o_q_pop(q_pop), .o_valid, .i_ready, .o_res(res)
    );

    assign o_seq_assigned        = res.seq_assigned;
    assign o_match_ok            = res.match_ok;
    assign o_ping_ms             = res.ping_ms;
    assign o_server_ms           = res.server_ms;
    assign o_interval_ms         = res.interval_ms;
    assign o_rate_value          = res.rate_value;
    assign o_rate_stale          = res.rate_stale;
    assign o_packets_last_window = res.packets_last_window;
    assign o_sent_total          = res.sent_total;
    assign o_recv_total          = res.recv_total;
    assign o_avg_interval_ms     = res.avg_interval_ms;
    assign o_avg_ready           = res.avg_ready;
endmodule
`default_nettype wire

// File: tb/tb_packet_latency_traffic_monitor_core.sv
// self-checking testbench for the packet latency traffic monitor core
`timescale 1ns / 1ps
module tb_packet_latency_traffic_monitor_core;
    import pltm_pkg::*;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        i_valid = 1'b0;
    logic        o_ready;
    logic [1:0]  i_op = '0;
    logic [31:0] i_now_ms = '0;
    logic [15:0] i_byte_count = '0;
    logic [6:0]  i_seq = '0;
    logic [15:0] i_server_hold_ms = '0;
    logic [6:0]  i_sample_index = '0;
    logic        o_valid;
    logic        i_ready = 1'b0;
    logic [6:0]  o_seq_assigned;
    logic        o_match_ok;
    logic signed [31:0] o_ping_ms;
    logic [15:0] o_server_ms;
    logic [31:0] o_interval_ms;
    logic [39:0] o_rate_value;
    logic        o_rate_stale;
    logic [31:0] o_packets_last_window;
    logic [31:0] o_sent_total;
    logic [31:0] o_recv_total;
    logic [31:0] o_avg_interval_ms;
    logic        o_avg_ready;
    logic        psel = 1'b0;
    logic        penable = 1'b0;
    logic        pwrite = 1'b0;
    logic [3:0]  paddr = '0;
    logic [31:0] pwdata = '0;
    logic [31:0] prdata;
    logic        pready;

    packet_latency_traffic_monitor_core dut (.*);

    always #10 i_clk = ~i_clk;

    // predictor state
    t_cfg        cfg;
    logic [6:0]  send_pos;
    logic [31:0] stamp_at [SEQ_SLOTS];
    logic        stamp_ok [SEQ_SLOTS];
    logic [31:0] smp_ping [SAMPLE_SLOTS];
    logic [15:0] smp_srv [SAMPLE_SLOTS];
    logic [31:0] smp_gap [SAMPLE_SLOTS];
    logic [6:0]  ring_pos;
    logic [31:0] last_rx;
    logic        got_rx;
    logic [39:0] gap_sum;
    logic [7:0]  gap_cnt;
    logic [31:0] win_start;
    logic [39:0] win_bytes;
    logic [31:0] win_pkts, closed_pkts, mean_gap, n_sent, n_recv;
    logic [39:0] closed_rate;

    t_result expected_q [$];
    int      err_cnt = 0;
    int      tx_idle = 0, rx_idle = 0;
    logic [31:0] clock_ms = 0;

    function automatic bit gap_counts(logic [31:0] v);
        return v != 0 && v < cfg.interval_limit_ms;
    endfunction

    task automatic add_bytes(logic [15:0] n);
        logic [40:0] s;
        s = {1'b0, win_bytes} + n;
        win_bytes = s[40] ? 40'hFF_FFFF_FFFF : s[39:0];
        win_pkts++;
    endtask

    task automatic predict_monitor(t_item it);
        t_result r;
        logic [31:0] dt, gap;
        logic [6:0]  p;
        logic [43:0] prod;
        r = '0;
        case (it.op)
            OP_SEND: begin
                add_bytes(it.byte_count);
                n_sent++;
                send_pos++;
                if (send_pos == 0) begin
                    foreach (stamp_ok[k]) stamp_ok[k] = 1'b0;
                end
                stamp_at[send_pos] = it.now_ms;
                stamp_ok[send_pos] = 1'b1;
                r.seq_assigned = send_pos;
            end
            OP_RECV: begin
                add_bytes(it.byte_count);
                n_recv++;
                if (stamp_ok[it.seq]) begin
                    p = ring_pos;
                    gap = 0;
                    smp_ping[p] = it.now_ms - stamp_at[it.seq] - it.server_hold_ms;
                    smp_srv[p] = it.server_hold_ms;
                    if (got_rx) begin
                        gap = it.now_ms - last_rx;
                        if (gap_counts(smp_gap[p])) begin
                            gap_sum -= smp_gap[p];
                            gap_cnt--;
                        end
                        smp_gap[p] = gap;
                        if (gap_counts(gap)) begin
                            gap_sum += gap;
                            gap_cnt++;
                        end
                    end
                    last_rx = it.now_ms;
                    got_rx = 1'b1;
                    ring_pos = p + 1;
                    stamp_ok[it.seq] = 1'b0;
                    r.match_ok = 1'b1;
                    r.ping_ms = smp_ping[p];
                    r.server_ms = it.server_hold_ms;
                    r.interval_ms = gap;
                end
            end
            OP_REPORT: begin
                dt = it.now_ms - win_start;
                if (dt > cfg.rate_window_ms) begin
                    prod = win_bytes * 44'd9;
                    closed_rate = prod[43:10];
                    win_start = it.now_ms;
                    closed_pkts = win_pkts;
                    win_pkts = 0;
                    win_bytes = 0;
                end
                if (ring_pos >= cfg.min_samples) begin
                    mean_gap = gap_cnt != 0 ? 32'(gap_sum / gap_cnt) : 32'd0;
                    r.avg_ready = 1'b1;
                end
                r.rate_value = closed_rate;
                r.rate_stale = dt > cfg.stale_limit_ms;
                r.packets_last_window = closed_pkts;
                r.sent_total = n_sent;
                r.recv_total = n_recv;
                r.avg_interval_ms = mean_gap;
            end
            default: begin
                r.match_ok = 1'b1;
                r.ping_ms = smp_ping[it.sample_index];
                r.server_ms = smp_srv[it.sample_index];
                r.interval_ms = smp_gap[it.sample_index];
            end
        endcase
        expected_q.push_back(r);
    endtask

    task automatic send_item(t_op op, logic [31:0] now, logic [15:0] nbytes,
                             logic [6:0] sq, logic [15:0] hold, logic [6:0] idx);
        t_item it;
        while ($urandom_range(99) < tx_idle) begin
            i_valid <= 1'b0;
            @(posedge i_clk);
        end
        it = '{op, now, nbytes, sq, hold, idx};
        i_valid <= 1'b1;
        i_op <= op;
        i_now_ms <= now;
        i_byte_count <= nbytes;
        i_seq <= sq;
        i_server_hold_ms <= hold;
        i_sample_index <= idx;
        @(posedge i_clk);
        while (!o_ready) @(posedge i_clk);
        predict_monitor(it);
    endtask

    task automatic drain_results();
        i_valid <= 1'b0;
        while (expected_q.size() != 0) @(posedge i_clk);
        repeat (60) @(posedge i_clk);
    endtask

    task automatic write_reg(t_reg idx, logic [31:0] v);
        psel <= 1'b1; pwrite <= 1'b1; paddr <= {idx, 2'b00}; pwdata <= v;
        @(posedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        while (!pready) @(posedge i_clk);
        psel <= 1'b0; penable <= 1'b0; pwrite <= 1'b0;
        @(posedge i_clk);
        case (idx)
            REG_RATE_WINDOW: cfg.rate_window_ms = v[15:0];
            REG_STALE_LIMIT: cfg.stale_limit_ms = v[15:0];
            REG_INTERVAL:    cfg.interval_limit_ms = v[15:0];
            default:         cfg.min_samples = v[6:0];
        endcase
    endtask

    task automatic set_config(logic [15:0] w, logic [15:0] s, logic [15:0] lim,
                              logic [6:0] m);
        drain_results();
        write_reg(REG_RATE_WINDOW, w);
        write_reg(REG_STALE_LIMIT, s);
        write_reg(REG_INTERVAL, lim);
        write_reg(REG_MIN_SAMPLES, m);
    endtask

    // result checker
    always @(posedge i_clk) begin
        t_result got, want;
        if (i_rst_n && o_valid && i_ready) begin
            got = '{o_seq_assigned, o_match_ok, o_ping_ms, o_server_ms, o_interval_ms,
                    o_rate_value, o_rate_stale, o_packets_last_window, o_sent_total,
                    o_recv_total, o_avg_interval_ms, o_avg_ready};
            if (expected_q.size() == 0) begin
                $display("%0t: result with none pending, actual %h", $time, got);
                err_cnt++;
            end else begin
                want = expected_q.pop_front();
                if (got !== want) begin
                    $display("%0t: beat mismatch expected %h actual %h", $time, want, got);
                    err_cnt++;
                end
            end
        end
        i_ready <= $urandom_range(99) >= rx_idle;
    end

    task automatic test_directed();
        send_item(OP_REPORT, 0, 0, 0, 0, 0);
        send_item(OP_READ, 0, 0, 0, 0, 7'h7F);
        send_item(OP_RECV, 5, 16'hFFFF, 3, 0, 0);      // no live stamp
        send_item(OP_SEND, 10, 16'hFFFF, 0, 0, 0);
        send_item(OP_SEND, 32'hFFFF_FFF0, 0, 0, 0, 0);
        send_item(OP_RECV, 32'h0000_0020, 100, 2, 16'hFFFF, 0);  // wraps, negative ping
        send_item(OP_RECV, 300, 100, 1, 0, 0);         // first interval
        send_item(OP_RECV, 300, 1, 1, 0, 0);           // stamp already cleared
        send_item(OP_REPORT, 2000, 0, 0, 0, 0);
        send_item(OP_READ, 0, 0, 0, 0, 0);
        send_item(OP_READ, 0, 0, 0, 0, 1);
        send_item(OP_REPORT, 32'hFFFF_FFFF, 0, 0, 0, 0);
        clock_ms = 3000;
    endtask

    // sends past a wrap of the sequence space
    task automatic test_seq_wrap();
        repeat (130) begin
            clock_ms += $urandom_range(3);
            send_item(OP_SEND, clock_ms, 16'($urandom), 0, 0, 0);
        end
        send_item(OP_RECV, clock_ms + 5, 10, 2, 1, 0);
        send_item(OP_RECV, clock_ms + 5, 10, 1, 1, 0);
    endtask

    task automatic test_random(int n);
        int kind;
        logic [6:0] sq;
        for (int k = 0; k < n; k++) begin
            clock_ms += $urandom_range(($urandom_range(9) == 0) ? 3000 : 60);
            kind = $urandom_range(99);
            if (kind < 35) send_item(OP_SEND, clock_ms, 16'($urandom), 7'($urandom),
                                     16'($urandom), 7'($urandom));
            else if (kind < 75) begin
                sq = ($urandom_range(4) == 0) ? 7'($urandom) : send_pos - 7'($urandom_range(4));
                send_item(OP_RECV, ($urandom_range(30) == 0) ? $urandom : clock_ms,
                          16'($urandom), sq,
                          $urandom_range(1) ? 16'($urandom_range(50)) : 16'($urandom),
                          7'($urandom));
            end else if (kind < 88) send_item(OP_REPORT, clock_ms, 16'($urandom),
                                             7'($urandom), 16'($urandom), 7'($urandom));
            else send_item(OP_READ, $urandom, 16'($urandom), 7'($urandom), 16'($urandom),
                           7'($urandom));
            if (k == n / 2) drain_results();   // hold until all results are back
        end
    endtask

    task automatic test_saturation();
        for (int k = 0; k < 40; k++)
            send_item(OP_RECV, clock_ms, 16'hFFFF, 7'h7F, 0, 0);
        clock_ms += 70000;
        send_item(OP_REPORT, clock_ms, 0, 0, 0, 0);
    endtask

    initial begin
        cfg = '{16'd1000, 16'd1100, 16'd2000, 7'd10};
        send_pos = 0; ring_pos = 0; last_rx = 0; got_rx = 0; gap_sum = 0; gap_cnt = 0;
        win_start = 0; win_bytes = 0; win_pkts = 0; closed_pkts = 0; closed_rate = 0;
        mean_gap = 0; n_sent = 0; n_recv = 0;
        foreach (stamp_ok[k]) begin
            stamp_ok[k] = 0; stamp_at[k] = 0;
        end
        foreach (smp_ping[k]) begin
            smp_ping[k] = 0; smp_srv[k] = 0; smp_gap[k] = 0;
        end
        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        tx_idle = 25; rx_idle = 82;
        test_directed();
        test_seq_wrap();
        set_config(16'd1, 16'd1, 16'd1, 7'd0);
        test_random(300);
        set_config(16'hFFFF, 16'hFFFF, 16'hFFFF, 7'd127);
        tx_idle = 82; rx_idle = 25;
        test_random(300);
        test_saturation();
        set_config(16'd50, 16'd80, 16'd40, 7'd3);
        tx_idle = 0; rx_idle = 0;
        test_random(500);
        set_config(16'd1000, 16'd1100, 16'd2000, 7'd10);
        test_random(500);
        drain_results();
        if (err_cnt == 0) $display("No mismatches found");
        else $display("Mismatches found");
        $finish;
    end

    initial begin
        #100ms;
        $display("Mismatches found");
        $finish;
    end
endmodule
